@@ rtl/core/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg - profile sample stream decoder package
// Parse phases, result kinds and the result record shared by the decoder.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int WORD_W = 64;
    localparam int NARROW_W = 32;
    localparam int CNT_W = 3;

    // context switch carries five payload words, committed on the fifth
    localparam logic [CNT_W-1:0] CTX_LAST_IDX = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_EVENT  = 3'd1,
        PH_TYPE   = 3'd2,
        PH_CTX    = 3'd3,
        PH_CPU    = 3'd4,
        PH_COOKIE = 3'd5,
        PH_DROP   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_RELOAD   = 2'd1,
        KIND_DANGLING = 2'd2,
        KIND_UNKNOWN  = 2'd3
    } kind_t;

    localparam logic [1:0] MODE_USER    = 2'd0;
    localparam logic [1:0] MODE_KERNEL  = 2'd1;
    localparam logic [1:0] MODE_UNKNOWN = 2'd2;

    localparam logic [WORD_W-1:0] REC_CONTEXT    = 64'd1;
    localparam logic [WORD_W-1:0] REC_CPU        = 64'd2;
    localparam logic [WORD_W-1:0] REC_IMAGE      = 64'd3;
    localparam logic [WORD_W-1:0] REC_KERNEL_IN  = 64'd4;
    localparam logic [WORD_W-1:0] REC_KERNEL_OUT = 64'd5;
    localparam logic [WORD_W-1:0] REC_MODULE     = 64'd6;

    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] event_res;
        logic [WORD_W-1:0] thread_id;
        logic [WORD_W-1:0] group_id;
        logic [WORD_W-1:0] app_id;
        logic [WORD_W-1:0] image_id;
        logic [WORD_W-1:0] cpu_id;
        logic [1:0]        kernel_mode;
    } result_t;

endpackage

@@ rtl/core/profile_sample_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// profile_sample_stream_decoder_top - profile sample stream decoder
// Decodes a profiling buffer word by word into tagged samples and events.
// ----------------------------------------------------------------------------
// The decoder takes one buffer word per clock unless the result side stalls,
// and gives at most one result per word. A word passes through an input
// register, the parse step and a result register. Words that only update
// the context produce no result. cfg_wide_words selects 64-bit (1, reset)
// or 32-bit (0) buffer words; it is to be written by the user only while the
// decoder has no words in flight, and the decoder itself does not enforce this.
module profile_sample_stream_decoder_top (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_wide_words,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [psd_pkg::WORD_W-1:0]  s_word,
    input  logic                        s_last,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_kind,
    output logic [psd_pkg::WORD_W-1:0]  m_pc,
    output logic [psd_pkg::WORD_W-1:0]  m_event_res,
    output logic [psd_pkg::WORD_W-1:0]  m_thread_id,
    output logic [psd_pkg::WORD_W-1:0]  m_group_id,
    output logic [psd_pkg::WORD_W-1:0]  m_app_id,
    output logic [psd_pkg::WORD_W-1:0]  m_image_id,
    output logic [psd_pkg::WORD_W-1:0]  m_cpu_id,
    output logic [1:0]                  m_kernel_mode
);

    logic                       wide_reg;
    logic                       in_valid_reg;
    logic [psd_pkg::WORD_W-1:0] in_word_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg;
    psd_pkg::result_t           out_res_reg;

    logic                       advance;
    logic                       emit;
    psd_pkg::result_t           res;

    // the parse step runs once the result slot is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    psd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .word    (in_word_reg),
        .last    (in_last_reg),
        .wide    (wide_reg),
        .emit    (emit),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            wide_reg <= cfg_wide_words;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
            in_last_reg <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_res_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_res_reg.kind;
    assign m_pc          = out_res_reg.pc;
    assign m_event_res   = out_res_reg.event_res;
    assign m_thread_id   = out_res_reg.thread_id;
    assign m_group_id    = out_res_reg.group_id;
    assign m_app_id      = out_res_reg.app_id;
    assign m_image_id    = out_res_reg.image_id;
    assign m_cpu_id      = out_res_reg.cpu_id;
    assign m_kernel_mode = out_res_reg.kernel_mode;

endmodule

@@ rtl/core/psd_parse.sv @@
// ----------------------------------------------------------------------------
// psd_parse - buffer word parser
// Holds the parse phase and the current context, and on each step turns one
// buffer word into at most one result record.
// ----------------------------------------------------------------------------
module psd_parse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [psd_pkg::WORD_W-1:0]  word,
    input  logic                        last,
    input  logic                        wide,
    output logic                        emit,
    output psd_pkg::result_t            res
);

    psd_pkg::phase_t phase_reg, phase_next;
    logic [psd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [psd_pkg::WORD_W-1:0] held_pc_reg, held_pc_next;
    logic [psd_pkg::WORD_W-1:0] new_thread_reg, new_thread_next;
    logic [psd_pkg::WORD_W-1:0] new_app_reg, new_app_next;
    logic [psd_pkg::WORD_W-1:0] cur_thread_reg, cur_thread_next;
    logic [psd_pkg::WORD_W-1:0] cur_group_reg, cur_group_next;
    logic [psd_pkg::WORD_W-1:0] cur_app_reg, cur_app_next;
    logic [psd_pkg::WORD_W-1:0] cur_image_reg, cur_image_next;
    logic [psd_pkg::WORD_W-1:0] cur_cpu_reg, cur_cpu_next;
    logic [1:0]                 cur_mode_reg, cur_mode_next;

    logic [psd_pkg::WORD_W-1:0] w;
    logic                       is_esc;
    logic                       code_payload;
    logic                       ctx_done;

    assign w = wide ? word
                    : {{(psd_pkg::WORD_W-psd_pkg::NARROW_W){1'b0}},
                       word[psd_pkg::NARROW_W-1:0]};
    assign is_esc = wide ? (&word) : (&word[psd_pkg::NARROW_W-1:0]);
    assign code_payload = (w == psd_pkg::REC_CONTEXT) ||
                          (w == psd_pkg::REC_CPU) ||
                          (w == psd_pkg::REC_IMAGE);
    assign ctx_done = (count_reg >= psd_pkg::CTX_LAST_IDX);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            psd_pkg::PH_IDLE: begin
                phase_next = is_esc ? psd_pkg::PH_TYPE : psd_pkg::PH_EVENT;
            end
            psd_pkg::PH_EVENT: begin
                phase_next = psd_pkg::PH_IDLE;
            end
            psd_pkg::PH_TYPE: begin
                if (w == psd_pkg::REC_CONTEXT) begin
                    phase_next = psd_pkg::PH_CTX;
                end else if (w == psd_pkg::REC_CPU) begin
                    phase_next = psd_pkg::PH_CPU;
                end else if (w == psd_pkg::REC_IMAGE) begin
                    phase_next = psd_pkg::PH_COOKIE;
                end else if ((w == psd_pkg::REC_KERNEL_IN) ||
                             (w == psd_pkg::REC_KERNEL_OUT) ||
                             (w == psd_pkg::REC_MODULE)) begin
                    phase_next = psd_pkg::PH_IDLE;
                end else begin
                    phase_next = psd_pkg::PH_DROP;
                end
            end
            psd_pkg::PH_CTX: begin
                if (ctx_done) begin
                    phase_next = psd_pkg::PH_IDLE;
                end
            end
            psd_pkg::PH_CPU,
            psd_pkg::PH_COOKIE: begin
                phase_next = psd_pkg::PH_IDLE;
            end
            psd_pkg::PH_DROP: begin
                phase_next = psd_pkg::PH_DROP;
            end
            default: begin
                phase_next = psd_pkg::PH_IDLE;
            end
        endcase
        // end of buffer returns everything to reset
        if (last) begin
            phase_next = psd_pkg::PH_IDLE;
        end
    end

    // result and context updates
    always_comb begin
        emit            = 1'b0;
        res.kind        = psd_pkg::KIND_DANGLING;
        res.pc          = '0;
        res.event_res   = '0;
        res.thread_id   = cur_thread_reg;
        res.group_id    = cur_group_reg;
        res.app_id      = cur_app_reg;
        res.image_id    = cur_image_reg;
        res.cpu_id      = cur_cpu_reg;
        res.kernel_mode = cur_mode_reg;

        count_next      = count_reg;
        held_pc_next    = held_pc_reg;
        new_thread_next = new_thread_reg;
        new_app_next    = new_app_reg;
        cur_thread_next = cur_thread_reg;
        cur_group_next  = cur_group_reg;
        cur_app_next    = cur_app_reg;
        cur_image_next  = cur_image_reg;
        cur_cpu_next    = cur_cpu_reg;
        cur_mode_next   = cur_mode_reg;

        case (phase_reg)
            psd_pkg::PH_IDLE: begin
                if (!is_esc) begin
                    held_pc_next = w;
                end
                emit = last;
            end
            psd_pkg::PH_EVENT: begin
                emit          = 1'b1;
                res.kind      = psd_pkg::KIND_SAMPLE;
                res.pc        = held_pc_reg;
                res.event_res = w;
            end
            psd_pkg::PH_TYPE: begin
                if (code_payload) begin
                    emit       = last;
                    count_next = '0;
                end else if (w == psd_pkg::REC_KERNEL_IN) begin
                    cur_mode_next = psd_pkg::MODE_KERNEL;
                end else if (w == psd_pkg::REC_KERNEL_OUT) begin
                    cur_mode_next = psd_pkg::MODE_USER;
                end else if (w == psd_pkg::REC_MODULE) begin
                    emit     = 1'b1;
                    res.kind = psd_pkg::KIND_RELOAD;
                end else begin
                    emit     = 1'b1;
                    res.kind = psd_pkg::KIND_UNKNOWN;
                end
            end
            psd_pkg::PH_CTX: begin
                if (count_reg == '0) begin
                    new_thread_next = w;
                end else if (count_reg == psd_pkg::CNT_W'(1)) begin
                    new_app_next = w;
                end
                if (ctx_done) begin
                    cur_thread_next = new_thread_reg;
                    cur_app_next    = new_app_reg;
                    cur_group_next  = w;
                    count_next      = '0;
                end else begin
                    count_next = count_reg + psd_pkg::CNT_W'(1);
                    emit       = last;
                end
            end
            psd_pkg::PH_CPU: begin
                cur_cpu_next = w;
            end
            psd_pkg::PH_COOKIE: begin
                cur_image_next = w;
            end
            default: begin
            end
        endcase

        if (last) begin
            count_next      = '0;
            held_pc_next    = '0;
            new_thread_next = '0;
            new_app_next    = '0;
            cur_thread_next = '1;
            cur_group_next  = '1;
            cur_app_next    = '0;
            cur_image_next  = '0;
            cur_cpu_next    = '1;
            cur_mode_next   = psd_pkg::MODE_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= psd_pkg::PH_IDLE;
            count_reg      <= '0;
            held_pc_reg    <= '0;
            new_thread_reg <= '0;
            new_app_reg    <= '0;
            cur_thread_reg <= '1;
            cur_group_reg  <= '1;
            cur_app_reg    <= '0;
            cur_image_reg  <= '0;
            cur_cpu_reg    <= '1;
            cur_mode_reg   <= psd_pkg::MODE_UNKNOWN;
        end else if (step) begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            held_pc_reg    <= held_pc_next;
            new_thread_reg <= new_thread_next;
            new_app_reg    <= new_app_next;
            cur_thread_reg <= cur_thread_next;
            cur_group_reg  <= cur_group_next;
            cur_app_reg    <= cur_app_next;
            cur_image_reg  <= cur_image_next;
            cur_cpu_reg    <= cur_cpu_next;
            cur_mode_reg   <= cur_mode_next;
        end
    end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - profile sample stream decoder testbench
// Feeds profiling buffers through the decoder, mostly under random stalls
// on both sides. Each result is checked field by field against a cycle-free
// decoder model or a fixed typed row; random buffers run in both word widths.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [psd_pkg::WORD_W-1:0] ONES = {psd_pkg::WORD_W{1'b1}};
    localparam int SEG_ITEMS = 160;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [psd_pkg::WORD_W-1:0] word;
        logic                       last;
        logic                       typed;
        psd_pkg::kind_t             kind;
        logic [psd_pkg::WORD_W-1:0] pc;
        logic [psd_pkg::WORD_W-1:0] ev;
    } dir_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_wide_words = 1'b1;
    logic                       s_valid = 1'b0;
    logic [psd_pkg::WORD_W-1:0] s_word = '0;
    logic                       s_last = 1'b0;
    logic                       m_ready = 1'b0;
    logic                       cfg_ready;
    logic                       s_ready;
    logic                       m_valid;
    logic [1:0]                 m_kind;
    logic [psd_pkg::WORD_W-1:0] m_pc;
    logic [psd_pkg::WORD_W-1:0] m_event_res;
    logic [psd_pkg::WORD_W-1:0] m_thread_id;
    logic [psd_pkg::WORD_W-1:0] m_group_id;
    logic [psd_pkg::WORD_W-1:0] m_app_id;
    logic [psd_pkg::WORD_W-1:0] m_image_id;
    logic [psd_pkg::WORD_W-1:0] m_cpu_id;
    logic [1:0]                 m_kernel_mode;

    // decoder model state
    logic                       wide_mode;
    psd_pkg::phase_t            parse_ph;
    logic [psd_pkg::CNT_W-1:0]  pay_cnt;
    logic [psd_pkg::WORD_W-1:0] pend_pc;
    logic [psd_pkg::WORD_W-1:0] pend_thread;
    logic [psd_pkg::WORD_W-1:0] pend_app;
    logic [psd_pkg::WORD_W-1:0] ctx_thread;
    logic [psd_pkg::WORD_W-1:0] ctx_group;
    logic [psd_pkg::WORD_W-1:0] ctx_app;
    logic [psd_pkg::WORD_W-1:0] ctx_image;
    logic [psd_pkg::WORD_W-1:0] ctx_cpu;
    logic [1:0]                 ctx_mode;

    psd_pkg::result_t sample_q[$];
    dir_row_t         dir_tab[$];
    int               n_errors = 0;
    int               n_live = 0;
    int               src_idle_pct = 14;
    int               sink_idle_pct = 45;

    profile_sample_stream_decoder_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_wide_words(cfg_wide_words),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_pc          (m_pc),
        .m_event_res   (m_event_res),
        .m_thread_id   (m_thread_id),
        .m_group_id    (m_group_id),
        .m_app_id      (m_app_id),
        .m_image_id    (m_image_id),
        .m_cpu_id      (m_cpu_id),
        .m_kernel_mode (m_kernel_mode)
    );

    always #4 aclk = ~aclk;

    function automatic void clear_context();
        parse_ph    = psd_pkg::PH_IDLE;
        pay_cnt     = '0;
        pend_pc     = '0;
        pend_thread = '0;
        pend_app    = '0;
        ctx_thread  = ONES;
        ctx_group   = ONES;
        ctx_app     = '0;
        ctx_image   = '0;
        ctx_cpu     = ONES;
        ctx_mode    = psd_pkg::MODE_UNKNOWN;
    endfunction

    function automatic psd_pkg::result_t tag_result(input psd_pkg::kind_t kind,
                                                    input logic [psd_pkg::WORD_W-1:0] pc,
                                                    input logic [psd_pkg::WORD_W-1:0] ev);
        psd_pkg::result_t r;
        r.kind        = kind;
        r.pc          = pc;
        r.event_res   = ev;
        r.thread_id   = ctx_thread;
        r.group_id    = ctx_group;
        r.app_id      = ctx_app;
        r.image_id    = ctx_image;
        r.cpu_id      = ctx_cpu;
        r.kernel_mode = ctx_mode;
        return r;
    endfunction

    // advances the model by one buffer word; returns 1 when a result is due
    function automatic bit decode_word(input logic [psd_pkg::WORD_W-1:0] raw,
                                       input logic lst,
                                       output psd_pkg::result_t res);
        logic [psd_pkg::WORD_W-1:0] w;
        logic [psd_pkg::WORD_W-1:0] esc;
        bit                         hit;
        w   = wide_mode ? raw
                        : {{(psd_pkg::WORD_W-psd_pkg::NARROW_W){1'b0}},
                           raw[psd_pkg::NARROW_W-1:0]};
        esc = wide_mode ? ONES
                        : {{(psd_pkg::WORD_W-psd_pkg::NARROW_W){1'b0}},
                           {psd_pkg::NARROW_W{1'b1}}};
        hit = 1'b0;
        res = '0;
        case (parse_ph)
            psd_pkg::PH_IDLE: begin
                if (w != esc)
                    pend_pc = w;
                if (lst) begin
                    res = tag_result(psd_pkg::KIND_DANGLING, '0, '0);
                    hit = 1'b1;
                end else begin
                    parse_ph = (w == esc) ? psd_pkg::PH_TYPE : psd_pkg::PH_EVENT;
                end
            end
            psd_pkg::PH_EVENT: begin
                res = tag_result(psd_pkg::KIND_SAMPLE, pend_pc, w);
                hit = 1'b1;
                parse_ph = psd_pkg::PH_IDLE;
            end
            psd_pkg::PH_TYPE: begin
                if (w == psd_pkg::REC_CONTEXT || w == psd_pkg::REC_CPU ||
                    w == psd_pkg::REC_IMAGE) begin
                    if (lst) begin
                        res = tag_result(psd_pkg::KIND_DANGLING, '0, '0);
                        hit = 1'b1;
                    end else begin
                        parse_ph = (w == psd_pkg::REC_CONTEXT) ? psd_pkg::PH_CTX :
                                   (w == psd_pkg::REC_CPU) ? psd_pkg::PH_CPU :
                                   psd_pkg::PH_COOKIE;
                        pay_cnt = '0;
                    end
                end else if (w == psd_pkg::REC_KERNEL_IN) begin
                    ctx_mode = psd_pkg::MODE_KERNEL;
                    parse_ph = psd_pkg::PH_IDLE;
                end else if (w == psd_pkg::REC_KERNEL_OUT) begin
                    ctx_mode = psd_pkg::MODE_USER;
                    parse_ph = psd_pkg::PH_IDLE;
                end else if (w == psd_pkg::REC_MODULE) begin
                    res = tag_result(psd_pkg::KIND_RELOAD, '0, '0);
                    hit = 1'b1;
                    parse_ph = psd_pkg::PH_IDLE;
                end else begin
                    res = tag_result(psd_pkg::KIND_UNKNOWN, '0, '0);
                    hit = 1'b1;
                    parse_ph = psd_pkg::PH_DROP;
                end
            end
            psd_pkg::PH_CTX: begin
                if (pay_cnt == 0)
                    pend_thread = w;
                else if (pay_cnt == 1)
                    pend_app = w;
                if (pay_cnt >= psd_pkg::CTX_LAST_IDX) begin
                    ctx_thread = pend_thread;
                    ctx_app    = pend_app;
                    ctx_group  = w;
                    pay_cnt    = '0;
                    parse_ph   = psd_pkg::PH_IDLE;
                end else begin
                    pay_cnt = pay_cnt + 1'b1;
                    if (lst) begin
                        res = tag_result(psd_pkg::KIND_DANGLING, '0, '0);
                        hit = 1'b1;
                    end
                end
            end
            psd_pkg::PH_CPU: begin
                ctx_cpu  = w;
                parse_ph = psd_pkg::PH_IDLE;
            end
            psd_pkg::PH_COOKIE: begin
                ctx_image = w;
                parse_ph  = psd_pkg::PH_IDLE;
            end
            default: ;
        endcase
        if (lst)
            clear_context();
        return hit;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [psd_pkg::WORD_W-1:0] got,
                                   input logic [psd_pkg::WORD_W-1:0] want);
        n_errors++;
        $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [psd_pkg::WORD_W-1:0] got,
                               input logic [psd_pkg::WORD_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // result side: random back-pressure, every accepted result checked in order
    always @(posedge aclk) begin : sink
        psd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sample_q.size() == 0) begin
                report_mismatch("result with none pending, kind", 64'(m_kind), '0);
            end else begin
                want = sample_q.pop_front();
                check_field("kind", 64'(m_kind), 64'(want.kind));
                check_field("pc", m_pc, want.pc);
                check_field("event_res", m_event_res, want.event_res);
                check_field("thread_id", m_thread_id, want.thread_id);
                check_field("group_id", m_group_id, want.group_id);
                check_field("app_id", m_app_id, want.app_id);
                check_field("image_id", m_image_id, want.image_id);
                check_field("cpu_id", m_cpu_id, want.cpu_id);
                check_field("kernel_mode", 64'(m_kernel_mode), 64'(want.kernel_mode));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // one buffer word; valid stays up between back-to-back words
    task automatic push_word(input logic [psd_pkg::WORD_W-1:0] w, input logic lst,
                             input bit typed, input psd_pkg::result_t fixed);
        psd_pkg::result_t r;
        bit               hit;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        s_last  <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (parse_ph != psd_pkg::PH_DROP)
            n_live++;
        hit = decode_word(w, lst, r);
        if (typed)
            sample_q.push_back(fixed);
        else if (hit)
            sample_q.push_back(r);
    endtask

    task automatic write_wide(input logic v);
        s_valid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_wide_words <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        wide_mode = v;
    endtask

    function automatic logic [psd_pkg::WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [psd_pkg::WORD_W-1:0] data_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONES;
            2: return 64'h0000_0000_ffff_ffff;
            3: return 64'hffff_ffff_0000_0000;
            4: return 64'($urandom_range(0, 7));
            default: return rand64();
        endcase
    endfunction

    // narrow mode ignores the upper half, so it is filled with noise there
    function automatic logic [psd_pkg::WORD_W-1:0] code_word(
        input logic [psd_pkg::NARROW_W-1:0] c);
        return wide_mode ? {{(psd_pkg::WORD_W-psd_pkg::NARROW_W){1'b0}}, c}
                         : {$urandom, c};
    endfunction

    function automatic logic [psd_pkg::WORD_W-1:0] esc_word();
        return wide_mode ? ONES : {$urandom, {psd_pkg::NARROW_W{1'b1}}};
    endfunction

    function automatic logic [psd_pkg::WORD_W-1:0] bad_code();
        case ($urandom_range(0, 4))
            0: return code_word(32'd0);
            1: return code_word(32'd7);
            2: return code_word($urandom_range(8, 1000));
            3: return wide_mode ? {$urandom | 32'h1, 32'd1} : code_word(32'd9);
            default: return rand64();
        endcase
    endfunction

    task automatic send_buffer(input int n_rec);
        logic [psd_pkg::WORD_W-1:0] words[$];
        int                         pick;
        int                         cut;
        for (int r = 0; r < n_rec; r++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                words.push_back(data_word());
                words.push_back(data_word());
            end else if (pick < 54) begin
                words.push_back(esc_word());
                words.push_back(code_word(psd_pkg::REC_CONTEXT[psd_pkg::NARROW_W-1:0]));
                repeat (5) words.push_back(data_word());
            end else if (pick < 62) begin
                words.push_back(esc_word());
                words.push_back(code_word(psd_pkg::REC_CPU[psd_pkg::NARROW_W-1:0]));
                words.push_back(data_word());
            end else if (pick < 70) begin
                words.push_back(esc_word());
                words.push_back(code_word(psd_pkg::REC_IMAGE[psd_pkg::NARROW_W-1:0]));
                words.push_back(data_word());
            end else if (pick < 77) begin
                words.push_back(esc_word());
                words.push_back(code_word(psd_pkg::REC_KERNEL_IN[psd_pkg::NARROW_W-1:0]));
            end else if (pick < 84) begin
                words.push_back(esc_word());
                words.push_back(code_word(psd_pkg::REC_KERNEL_OUT[psd_pkg::NARROW_W-1:0]));
            end else if (pick < 90) begin
                words.push_back(esc_word());
                words.push_back(code_word(psd_pkg::REC_MODULE[psd_pkg::NARROW_W-1:0]));
            end else if (pick < 93) begin
                words.push_back(esc_word());
                words.push_back(bad_code());
                repeat ($urandom_range(0, 3)) words.push_back(rand64());
            end else begin
                words.push_back(rand64());
            end
        end
        // cut the tail now and then so the buffer may end inside a record
        if ($urandom_range(0, 3) == 0 && words.size() > 1) begin
            cut = $urandom_range(1, (words.size() > 4) ? 3 : words.size() - 1);
            repeat (cut) void'(words.pop_back());
        end
        foreach (words[i])
            push_word(words[i], i == words.size() - 1, 1'b0, '0);
    endtask

    task automatic add_row(input logic [psd_pkg::WORD_W-1:0] w, input logic lst,
                           input logic typed, input psd_pkg::kind_t kind,
                           input logic [psd_pkg::WORD_W-1:0] pc,
                           input logic [psd_pkg::WORD_W-1:0] ev);
        dir_row_t row;
        row.word  = w;
        row.last  = lst;
        row.typed = typed;
        row.kind  = kind;
        row.pc    = pc;
        row.ev    = ev;
        dir_tab.push_back(row);
    endtask

    initial begin
        psd_pkg::result_t fixed;
        wide_mode = 1'b1;
        clear_context();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // typed rows follow no context record in their buffer, so they carry the reset context
        add_row(64'h0000_0000_0000_0123, 1'b1, 1'b1, psd_pkg::KIND_DANGLING, '0, '0);
        add_row(ONES, 1'b1, 1'b1, psd_pkg::KIND_DANGLING, '0, '0);
        add_row('0, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(ONES, 1'b1, 1'b1, psd_pkg::KIND_SAMPLE, '0, ONES);
        add_row(ONES, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(psd_pkg::REC_MODULE, 1'b0, 1'b1, psd_pkg::KIND_RELOAD, '0, '0);
        add_row(ONES, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(64'd7, 1'b0, 1'b1, psd_pkg::KIND_UNKNOWN, '0, '0);
        add_row(ONES, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(psd_pkg::REC_KERNEL_OUT, 1'b1, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(ONES, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(psd_pkg::REC_CONTEXT, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(ONES, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(64'h8000_0000_0000_0001, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(64'h0000_0000_ffff_ffff, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(64'h1234_5678_9abc_def0, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row('0, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(ONES, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(psd_pkg::REC_CPU, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(64'd3, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(ONES, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(psd_pkg::REC_KERNEL_IN, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(64'hffff_ffff_ffff_fffe, 1'b0, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);
        add_row(64'h5555_aaaa_5555_aaaa, 1'b1, 1'b0, psd_pkg::KIND_SAMPLE, '0, '0);

        foreach (dir_tab[i]) begin
            fixed = '0;
            fixed.kind        = dir_tab[i].kind;
            fixed.pc          = dir_tab[i].pc;
            fixed.event_res   = dir_tab[i].ev;
            fixed.thread_id   = ONES;
            fixed.group_id    = ONES;
            fixed.cpu_id      = ONES;
            fixed.kernel_mode = psd_pkg::MODE_UNKNOWN;
            push_word(dir_tab[i].word, dir_tab[i].last, dir_tab[i].typed, fixed);
        end

        // three stall profiles, each run in both word widths
        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    src_idle_pct  = 14;
                    sink_idle_pct = 45;
                end
                1: begin
                    src_idle_pct  = 45;
                    sink_idle_pct = 14;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            write_wide(seg % 2 == 1);
            n_live = 0;
            while (n_live < SEG_ITEMS)
                send_buffer($urandom_range(1, 6));
        end

        s_valid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/psd_pkg.sv
rtl/core/psd_parse.sv
rtl/core/profile_sample_stream_decoder_top.sv
verif/testbench.sv
